// ===== rtl/jmss_pkg.sv =====
// Types, marker codes and constants shared by the JPEG marker segment scanner.
`default_nettype none
package jmss_pkg;

    localparam logic [7:0] MARK_FILL = 8'hFF;
    localparam logic [7:0] MARK_RST0 = 8'hD0;
    localparam logic [7:0] MARK_SOI  = 8'hD8;
    localparam logic [7:0] MARK_EOI  = 8'hD9;
    localparam logic [7:0] MARK_SOS  = 8'hDA;
    localparam logic [7:0] MARK_APP0 = 8'hE0;
    localparam logic [7:0] MARK_APP1 = 8'hE1;

    localparam logic [2:0]  EXIF_TAG_LEN = 3'd6;
    localparam logic [15:0] EXIF_MIN_LEN = 16'd8;
    localparam logic [15:0] LEN_FIELD    = 16'd2;

    typedef enum logic [4:0] {
        PH_SEEK_FF   = 5'b00001,
        PH_SEEK_MARK = 5'b00010,
        PH_LEN_HI    = 5'b00100,
        PH_LEN_LO    = 5'b01000,
        PH_PAYLOAD   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        END_SOS   = 2'd0,
        END_EOI   = 2'd1,
        END_TRUNC = 2'd2
    } end_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] insert_position;
        logic [7:0] exif_segment_index;
        logic       exif_found;
        logic [7:0] segment_total;
        end_kind_t  end_kind;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  marker;
        logic [7:0]  len_hi;
        logic [15:0] payload_left;
        logic [2:0]  id_pos;
        logic        id_match;
        logic [7:0]  seg_cnt;
        logic [7:0]  insert_pos;
        logic [7:0]  exif_idx;
        logic        exif_seen;
        logic        done;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:        PH_SEEK_FF,
        marker:       8'd0,
        len_hi:       8'd0,
        payload_left: 16'd0,
        id_pos:       3'd0,
        id_match:     1'b0,
        seg_cnt:      8'd0,
        insert_pos:   8'd0,
        exif_idx:     8'd0,
        exif_seen:    1'b0,
        done:         1'b0
    };

    // "Exif" followed by two zero bytes
    function automatic logic [7:0] exif_tag_byte(input logic [2:0] pos);
        logic [7:0] tag;
        case (pos)
            3'd0:    tag = 8'h45;
            3'd1:    tag = 8'h78;
            3'd2:    tag = 8'h69;
            3'd3:    tag = 8'h66;
            default: tag = 8'h00;
        endcase
        return tag;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/jmss_in_reg.sv =====
// Input register: holds one accepted byte item until the scanner consumes it.
`default_nettype none
module jmss_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire jmss_pkg::in_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output jmss_pkg::in_item_t     item
);
    import jmss_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    // advancing consumes the held item, so it needs one
    assert property (@(posedge aclk) disable iff (!aresetn) advance |-> valid_reg)
        else $error("jmss_in_reg: advance without a held item");

endmodule
`default_nettype wire

// ===== rtl/jmss_scan.sv =====
// Marker scan state and its per-byte next-state logic.
`default_nettype none
module jmss_scan #(
    parameter int MAX_SEGMENTS = 255
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire jmss_pkg::in_item_t item,
    input  wire logic               advance,
    output logic                    emit,
    output jmss_pkg::result_t       result
);
    import jmss_pkg::*;

    localparam logic [7:0] SEG_CAP = 8'((MAX_SEGMENTS < 255) ? MAX_SEGMENTS : 255);

    scan_state_t state_reg, state_next;
    scan_state_t cur;
    logic [15:0] seg_size;
    logic [2:0]  pos_inc;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v >= SEG_CAP) ? SEG_CAP : v + 8'd1;
    endfunction

    always_comb begin
        cur        = item.first_byte ? SCAN_RESET : state_reg;
        state_next = cur;
        emit       = 1'b0;
        seg_size   = {cur.len_hi, item.data_byte};
        pos_inc    = cur.id_pos + 3'd1;
        result.end_kind = END_TRUNC;

        if (!cur.done) begin
            case (cur.phase)
                PH_SEEK_FF: begin
                    if (item.data_byte == MARK_FILL) begin
                        state_next.phase = PH_SEEK_MARK;
                    end
                end
                PH_SEEK_MARK: begin
                    // drop fill bytes
                    if (item.data_byte != MARK_FILL) begin
                        state_next.marker = item.data_byte;
                        if (item.data_byte == MARK_SOS) begin
                            emit            = 1'b1;
                            result.end_kind = END_SOS;
                        end else if (item.data_byte == MARK_EOI) begin
                            emit            = 1'b1;
                            result.end_kind = END_EOI;
                        end else if (item.data_byte inside {[MARK_RST0:MARK_SOI]}) begin
                            state_next.seg_cnt = sat_inc(cur.seg_cnt);
                            state_next.phase   = PH_SEEK_FF;
                        end else begin
                            if (item.data_byte == MARK_APP0) begin
                                state_next.insert_pos = sat_inc(cur.seg_cnt);
                            end
                            state_next.phase = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI: begin
                    state_next.len_hi = item.data_byte;
                    state_next.phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    state_next.payload_left = (seg_size > LEN_FIELD) ? seg_size - LEN_FIELD
                                                                     : 16'd0;
                    state_next.id_pos   = 3'd0;
                    state_next.id_match = (cur.marker == MARK_APP1) &&
                                          (seg_size >= EXIF_MIN_LEN);
                    if (seg_size <= LEN_FIELD) begin
                        state_next.seg_cnt = sat_inc(cur.seg_cnt);
                        state_next.phase   = PH_SEEK_FF;
                    end else begin
                        state_next.phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (cur.id_match && (cur.id_pos < EXIF_TAG_LEN)) begin
                        if (item.data_byte != exif_tag_byte(cur.id_pos)) begin
                            state_next.id_match = 1'b0;
                        end else begin
                            state_next.id_pos = pos_inc;
                            if (pos_inc == EXIF_TAG_LEN) begin
                                state_next.exif_seen = 1'b1;
                                state_next.exif_idx  = cur.seg_cnt;
                                state_next.id_match  = 1'b0;
                            end
                        end
                    end
                    state_next.payload_left = cur.payload_left - 16'd1;
                    if (cur.payload_left == 16'd1) begin
                        state_next.seg_cnt = sat_inc(cur.seg_cnt);
                        state_next.phase   = PH_SEEK_FF;
                    end
                end
                default: begin
                    state_next.phase = PH_SEEK_FF;
                end
            endcase

            if (item.last_byte && !emit) begin
                emit            = 1'b1;
                result.end_kind = END_TRUNC;
            end
            if (emit) begin
                state_next.done = 1'b1;
            end
        end

        result.insert_position    = state_next.insert_pos;
        result.exif_segment_index = state_next.exif_idx;
        result.exif_found         = state_next.exif_seen;
        result.segment_total      = state_next.seg_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.seg_cnt <= SEG_CAP) && (state_reg.insert_pos <= SEG_CAP))
        else $error("jmss_scan: count above saturation limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.exif_idx <= state_reg.seg_cnt)
        else $error("jmss_scan: Exif index ahead of segment count");

    // once finished, only a new file start changes the state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.done && advance && !item.first_byte) |=> $stable(state_reg))
        else $error("jmss_scan: state moved after scan end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.done && !item.first_byte) |-> !emit)
        else $error("jmss_scan: result after scan end");

endmodule
`default_nettype wire

// ===== rtl/jmss_out_reg.sv =====
// Result register: holds one summary item until the receiver takes it.
`default_nettype none
module jmss_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire jmss_pkg::result_t load_result,
    output logic                   free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output jmss_pkg::result_t      m_result
);
    import jmss_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            result_reg <= load_result;
        end
    end

    // a load must never overwrite an item still waiting
    assert property (@(posedge aclk) disable iff (!aresetn) load |-> free)
        else $error("jmss_out_reg: load while result stalled");

endmodule
`default_nettype wire

// ===== rtl/jpeg_marker_segment_scanner.sv =====
// Top level of the JPEG marker segment scanner.
//
// Input channel (s_): one byte of a JPEG file per item. s_tuser marks the first
// byte of a new file and clears the scan state; s_tlast marks the last byte.
// Result channel (m_): one summary item per file, at SOS, EOI or the byte
// flagged last (end_kind in m_tuser). After that, bytes are taken and dropped
// until the next first byte.
// A byte accepted into the input register is scanned there by combinational
// logic, and its result is registered in the result register, from which it
// drives m_. Throughput is one byte per cycle while no result-causing byte
// waits on a stalled receiver; the scan state advances once per accepted byte.
// Reset (aresetn low, synchronous) empties both registers and returns the scan
// to the search for 0xFF.
// When the receiver stalls, the waiting result holds; bytes that cause no
// result keep flowing, and one that would cause a result waits in the input
// register, so s_tready falls only then.
`default_nettype none
module jpeg_marker_segment_scanner #(
    parameter int MAX_SEGMENTS = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] first_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] insert_position, [15:8] exif_segment_index, [16] exif_found,
    // [24:17] segment_total, [31:25] zero
    output logic [31:0]      m_tdata,
    output logic [1:0]       m_tuser    // [1:0] end_kind
);
    import jmss_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     emit;
    logic     out_free;
    logic     advance;
    result_t  scan_result;
    result_t  m_result;

    assign s_item.data_byte  = s_tdata;
    assign s_item.first_byte = s_tuser;
    assign s_item.last_byte  = s_tlast;

    // hold an item that would emit while the result register is occupied
    assign advance = item_valid && (!emit || out_free);

    jmss_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jmss_scan #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .emit    (emit),
        .result  (scan_result)
    );

    jmss_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && emit),
        .load_result (scan_result),
        .free        (out_free),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {7'd0, m_result.segment_total, m_result.exif_found,
                      m_result.exif_segment_index, m_result.insert_position};
    assign m_tuser = m_result.end_kind;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("jpeg_marker_segment_scanner: undefined end kind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (item_valid && emit && !out_free))
        else $error("jpeg_marker_segment_scanner: input stalled without cause");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("jpeg_marker_segment_scanner: result valid after reset");

endmodule
`default_nettype wire
